@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bit-packed array access block.
// Shared types, constants and helpers; no dependencies.
package bpa_pkg;

  localparam int STORE_WORDS_DEF = 1024;
  localparam int WORD_BITS       = 32;
  localparam int WIDTH_W         = 6;
  localparam int SLOT_W          = 15;
  localparam int POS_W           = SLOT_W + WIDTH_W;
  localparam int OFF_W           = 5;
  localparam int WORD_IDX_W      = POS_W - OFF_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 6'd32;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    slot_index;
    logic [WORD_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    logic                 out_of_range;
  } out_item_t;

  // Where a slot lands: out-of-range flag, word parity, next-word presence, bit offset.
  typedef struct packed {
    logic             oor;
    logic             word_odd;
    logic             has_next;
    logic [OFF_W-1:0] off;
  } slot_loc_t;

  typedef struct packed {
    logic even;
    logic odd;
  } bank_wen_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    if (v == '0) begin
      r = 6'd1;
    end else if (v > WIDTH_MAX) begin
      r = WIDTH_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/bpa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bpa_addr.sv @@
`timescale 1ns / 1ps
// Slot address math: bit position, range check, bank addresses.
// Depends on bpa_pkg.
module bpa_addr
  import bpa_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2,
  localparam int ODD_DEPTH  = STORE_WORDS / 2,
  localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1,
  localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1
) (
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic [WIDTH_W-1:0] width,
  output slot_loc_t          loc,
  output logic [EVEN_AW-1:0] even_addr,
  output logic [ODD_AW-1:0]  odd_addr
);

  localparam longint CAP_BITS = longint'(STORE_WORDS) * longint'(WORD_BITS);

  logic [POS_W-1:0]      pos;
  logic [POS_W:0]        pos_end;
  logic [WORD_IDX_W-1:0] word;
  logic [WORD_IDX_W:0]   word_inc;
  logic [WORD_IDX_W-1:0] half_inc;

  always_comb begin
    pos          = POS_W'(slot_index) * POS_W'(width);
    pos_end      = {1'b0, pos} + (POS_W + 1)'(width);
    word         = pos[POS_W-1:OFF_W];
    word_inc     = {1'b0, word} + (WORD_IDX_W + 1)'(1);
    half_inc     = {1'b0, word[WORD_IDX_W-1:1]} + WORD_IDX_W'(1);
    loc.oor      = pos_end > (POS_W + 1)'(CAP_BITS);
    loc.word_odd = word[0];
    loc.has_next = word_inc < (WORD_IDX_W + 1)'(STORE_WORDS);
    loc.off      = pos[OFF_W-1:0];
    // Words w and w+1 always sit in opposite banks.
    even_addr    = word[0] ? EVEN_AW'(half_inc) : EVEN_AW'(word[WORD_IDX_W-1:1]);
    odd_addr     = ODD_AW'(word[WORD_IDX_W-1:1]);
  end

endmodule

@@ rtl/bpa_merge.sv @@
`timescale 1ns / 1ps
// Field extract and insert over the two words a slot may span.
// Depends on bpa_pkg.
module bpa_merge
  import bpa_pkg::*;
(
  input  logic                 kind,
  input  logic [WORD_BITS-1:0] write_value,
  input  logic [WIDTH_W-1:0]   width,
  input  slot_loc_t            loc,
  input  logic [WORD_BITS-1:0] even_rdata,
  input  logic [WORD_BITS-1:0] odd_rdata,
  output logic [WORD_BITS-1:0] read_value,
  output logic [WORD_BITS-1:0] even_wdata,
  output logic [WORD_BITS-1:0] odd_wdata,
  output bank_wen_t            wen
);

  logic [WORD_BITS-1:0]   hi;
  logic [WORD_BITS-1:0]   lo;
  logic [2*WORD_BITS-1:0] cat;
  logic [2*WORD_BITS-1:0] cat_new;
  logic [2*WORD_BITS-1:0] extracted;
  logic [2*WORD_BITS-1:0] field_mask;
  logic [2*WORD_BITS-1:0] field_val;
  logic [WORD_BITS-1:0]   mask;
  logic [OFF_W+1:0]       shift;
  logic                   do_write;

  always_comb begin
    hi         = loc.word_odd ? odd_rdata : even_rdata;
    lo         = loc.has_next ? (loc.word_odd ? even_rdata : odd_rdata) : '0;
    cat        = {hi, lo};
    // MSB of the slot sits at bit 63 - off of the concatenation.
    shift      = 7'd64 - {2'b00, loc.off} - {1'b0, width};
    mask       = {WORD_BITS{1'b1}} >> (WIDTH_MAX - width);
    extracted  = cat >> shift;
    field_mask = {{WORD_BITS{1'b0}}, mask} << shift;
    field_val  = {{WORD_BITS{1'b0}}, write_value & mask} << shift;
    cat_new    = (cat & ~field_mask) | field_val;

    do_write   = (kind == KIND_WRITE) && !loc.oor;
    read_value = ((kind == KIND_READ) && !loc.oor) ? (extracted[WORD_BITS-1:0] & mask) : '0;
    even_wdata = loc.word_odd ? cat_new[WORD_BITS-1:0] : cat_new[2*WORD_BITS-1:WORD_BITS];
    odd_wdata  = loc.word_odd ? cat_new[2*WORD_BITS-1:WORD_BITS] : cat_new[WORD_BITS-1:0];
    wen.even   = do_write && (!loc.word_odd || loc.has_next);
    wen.odd    = do_write && (loc.word_odd || loc.has_next);
  end

endmodule

@@ rtl/bit_packed_array_access.sv @@
`timescale 1ns / 1ps
// Top level of the bit-packed array access block.
// Depends on bpa_pkg, bpa_ram, bpa_addr and bpa_merge.
//
// Reads and writes unsigned values of 1 to 32 bits packed MSB first in a store of
// STORE_WORDS 32-bit words. One item is accepted per cycle when the result side
// keeps up; an item passes the input register, the memory read and the result
// register. The store is split into an even-word and an odd-word bank, each with
// one read and one write port, so a slot spanning two words is read and rewritten
// in a single pass; the write of the previous item is forwarded to the next. After
// reset a clearing pass over the (STORE_WORDS + 1) / 2 even-bank addresses zeroes
// the store, during which no item is accepted. A stalled result holds the whole
// pipeline.
module bit_packed_array_access
  import bpa_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  in_item_t           item,
  output logic               result_valid,
  input  logic               result_stall,
  output out_item_t          result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIDTH_W-1:0] cfg_data
);

  localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int ODD_DEPTH  = STORE_WORDS / 2;
  localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
  localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
  localparam int CLR_W      = $clog2(EVEN_DEPTH + 1);

  logic [WIDTH_W-1:0]   value_width;
  logic [WIDTH_W-1:0]   width;

  logic                 clear_busy;
  logic [CLR_W-1:0]     clear_cnt;
  logic                 advance;

  logic                 a_valid;
  in_item_t             a_item;
  slot_loc_t            a_loc;
  logic [EVEN_AW-1:0]   a_even_addr;
  logic [ODD_AW-1:0]    a_odd_addr;

  logic                 b_valid;
  logic                 b_kind;
  logic [WORD_BITS-1:0] b_write_value;
  slot_loc_t            b_loc;
  logic [EVEN_AW-1:0]   b_even_addr;
  logic [ODD_AW-1:0]    b_odd_addr;

  logic [WORD_BITS-1:0] even_rdata;
  logic [WORD_BITS-1:0] odd_rdata;
  logic [WORD_BITS-1:0] even_cur;
  logic [WORD_BITS-1:0] odd_cur;
  logic [WORD_BITS-1:0] even_wdata;
  logic [WORD_BITS-1:0] odd_wdata;
  logic [WORD_BITS-1:0] b_read_value;
  bank_wen_t            b_wen;

  logic                 fwd_even_en;
  logic [EVEN_AW-1:0]   fwd_even_addr;
  logic [WORD_BITS-1:0] fwd_even_data;
  logic                 fwd_odd_en;
  logic [ODD_AW-1:0]    fwd_odd_addr;
  logic [WORD_BITS-1:0] fwd_odd_data;

  logic                 even_we;
  logic [EVEN_AW-1:0]   even_waddr;
  logic [WORD_BITS-1:0] even_wd;
  logic                 odd_we;
  logic [ODD_AW-1:0]    odd_waddr;
  logic [WORD_BITS-1:0] odd_wd;
  logic                 item_we_even;
  logic                 item_we_odd;

  assign cfg_ready  = 1'b1;
  assign width      = eff_width(value_width);
  assign advance    = !result_valid || !result_stall;
  assign item_stall = clear_busy || !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_width <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      value_width <= cfg_data;
    end
  end

  // Clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_cnt  <= '0;
    end else if (clear_busy) begin
      clear_cnt <= clear_cnt + CLR_W'(1);
      if (clear_cnt == CLR_W'(EVEN_DEPTH - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  bpa_addr #(
    .STORE_WORDS (STORE_WORDS)
  ) u_addr (
    .slot_index (a_item.slot_index),
    .width      (width),
    .loc        (a_loc),
    .even_addr  (a_even_addr),
    .odd_addr   (a_odd_addr)
  );

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
      fwd_even_en  <= 1'b0;
      fwd_odd_en   <= 1'b0;
    end else if (advance) begin
      a_valid      <= item_valid && !item_stall;
      b_valid      <= a_valid;
      result_valid <= b_valid;
      fwd_even_en  <= item_we_even;
      fwd_odd_en   <= item_we_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item        <= item;
      b_kind        <= a_item.kind;
      b_write_value <= a_item.write_value;
      b_loc         <= a_loc;
      b_even_addr   <= a_even_addr;
      b_odd_addr    <= a_odd_addr;
      result.read_value   <= b_read_value;
      result.out_of_range <= b_loc.oor;
      fwd_even_addr <= b_even_addr;
      fwd_even_data <= even_wdata;
      fwd_odd_addr  <= b_odd_addr;
      fwd_odd_data  <= odd_wdata;
    end
  end

  // Previous item's write is not yet visible in the read data.
  assign even_cur = (fwd_even_en && fwd_even_addr == b_even_addr) ? fwd_even_data : even_rdata;
  assign odd_cur  = (fwd_odd_en && fwd_odd_addr == b_odd_addr) ? fwd_odd_data : odd_rdata;

  bpa_merge u_merge (
    .kind        (b_kind),
    .write_value (b_write_value),
    .width       (width),
    .loc         (b_loc),
    .even_rdata  (even_cur),
    .odd_rdata   (odd_cur),
    .read_value  (b_read_value),
    .even_wdata  (even_wdata),
    .odd_wdata   (odd_wdata),
    .wen         (b_wen)
  );

  assign item_we_even = advance && b_valid && b_wen.even;
  assign item_we_odd  = advance && b_valid && b_wen.odd;

  always_comb begin
    if (clear_busy) begin
      even_we    = 1'b1;
      even_waddr = EVEN_AW'(clear_cnt);
      even_wd    = '0;
      odd_we     = clear_cnt < CLR_W'(ODD_DEPTH);
      odd_waddr  = ODD_AW'(clear_cnt);
      odd_wd     = '0;
    end else begin
      even_we    = item_we_even;
      even_waddr = b_even_addr;
      even_wd    = even_wdata;
      odd_we     = item_we_odd;
      odd_waddr  = b_odd_addr;
      odd_wd     = odd_wdata;
    end
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (EVEN_DEPTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wd),
    .re    (advance),
    .raddr (a_even_addr),
    .rdata (even_rdata)
  );

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ODD_DEPTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wd),
    .re    (advance),
    .raddr (a_odd_addr),
    .rdata (odd_rdata)
  );

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> (!a_valid && !b_valid && !result_valid))
    else $error("item in flight during clearing pass");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_of_range) |-> (result.read_value == '0))
    else $error("out-of-range result carries data");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(b_valid) && $stable(a_valid) && !$past(even_we) && !$past(odd_we)))
    else $error("pipeline moved or wrote while stalled");

  a_fwd_from_item: assert property (@(posedge clk) disable iff (rst)
    (fwd_even_en || fwd_odd_en) |-> (!clear_busy && result_valid))
    else $error("forward register set without a finished write");

endmodule

@@ sim/bpa_checker.sv @@
`timescale 1ns / 1ps
// Checker for the bit-packed array access block: watches the item, result and
// width-register channels, predicts each result and compares. Depends on bpa_pkg.
module bpa_checker
  import bpa_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  in_item_t           item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  out_item_t          result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [WIDTH_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  logic [WORD_BITS-1:0] shadow_words [STORE_WORDS];
  logic [WIDTH_W-1:0]   width_code;
  out_item_t            expected_results [$];
  out_item_t            want;
  int                   mismatches;

  // Reads or updates the shadow store; returns the result the block must give.
  function automatic out_item_t apply_access(input in_item_t it);
    int unsigned w;
    int unsigned pos;
    int unsigned word_at;
    int unsigned off;
    int unsigned sh;
    bit          has_next;
    logic [63:0] pair;
    logic [63:0] mask;
    out_item_t   r;
    w = (width_code == 0) ? 1 : ((width_code > 32) ? 32 : width_code);
    pos = it.slot_index * w;
    r = '0;
    if (pos + w > STORE_WORDS * WORD_BITS) begin
      r.out_of_range = 1'b1;
      return r;
    end
    word_at  = pos / WORD_BITS;
    off      = pos % WORD_BITS;
    has_next = (word_at + 1) < STORE_WORDS;
    pair[63:32] = shadow_words[word_at];
    pair[31:0]  = 32'h0;
    if (has_next) begin
      pair[31:0] = shadow_words[word_at + 1];
    end
    sh   = 64 - off - w;
    mask = (64'h1 << w) - 64'h1;
    if (it.kind == KIND_READ) begin
      r.read_value = 32'((pair >> sh) & mask);
    end else begin
      pair = (pair & ~(mask << sh)) | ((64'(it.write_value) & mask) << sh);
      shadow_words[word_at] = pair[63:32];
      if (has_next) begin
        shadow_words[word_at + 1] = pair[31:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        shadow_words[i] = '0;
      end
      width_code = WIDTH_RESET;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, result.read_value);
            mismatches++;
          end
          if (result.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %b, got %b", want.out_of_range,
                   result.out_of_range);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        width_code = cfg_data;
      end
      if (item_valid && !item_stall) begin
        expected_results.push_back(apply_access(item));
      end
    end
    errors  <= mismatches;
    pending <= expected_results.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the bit-packed array access block: drives items and width
// settings, stalls results, gives the verdict. Depends on bpa_pkg and bpa_checker.
module tb;
  import bpa_pkg::*;

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  in_item_t           item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  out_item_t          result;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [WIDTH_W-1:0] cfg_data     = '0;
  int                 errors;
  int                 pending;

  int burst_left = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_widths   = 0;

  bit [WIDTH_W-1:0] phase_codes [14] = '{1, 32, 0, 63, 5, 13, 31, 17, 3, 7, 24, 33, 2, 11};

  bit_packed_array_access dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  bpa_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result-side stall: the mode is redrawn at random when its countdown runs out.
  int      stall_mode = 0;
  int      stall_left = 0;
  bit [1:0] stall_phase = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(64, 255);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 1) == 1);
      2: result_stall <= (stall_phase != 2'd0);
      default: result_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic put(input logic k, input int slot, input logic [WORD_BITS-1:0] v);
    in_item_t it;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
    end
    it.kind        = k;
    it.slot_index  = slot[SLOT_W-1:0];
    it.write_value = v;
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    if (k == KIND_READ) n_reads++;
    else n_writes++;
  endtask

  // Drains the pipeline so the width register can be rewritten.
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] code);
    settle();
    cfg_data  <= code;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_widths++;
  endtask

  initial begin
    int w;
    int nslots;
    int base;
    int slot;
    int r;
    logic k;
    logic [WORD_BITS-1:0] v;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset width of 8: extremes, last slot without a next word, beyond capacity.
    put(KIND_WRITE, 0, 32'hFFFF_FFFF);
    put(KIND_READ, 0, 32'h0);
    put(KIND_WRITE, 4095, 32'h0000_00A5);
    put(KIND_READ, 4095, 32'h0);
    put(KIND_READ, 4096, 32'h0);
    put(KIND_WRITE, 4096, 32'h1234_5678);
    put(KIND_READ, 32767, 32'h0);
    // Full width, no shift by 32.
    write_width(6'd32);
    put(KIND_WRITE, 1023, 32'hDEAD_BEEF);
    put(KIND_READ, 1023, 32'h0);
    put(KIND_WRITE, 0, 32'hFFFF_FFFF);
    put(KIND_READ, 0, 32'h0);
    put(KIND_READ, 1024, 32'h0);
    // Zero code acts as one bit.
    write_width(6'd0);
    put(KIND_WRITE, 32767, 32'hFFFF_FFFF);
    put(KIND_READ, 32767, 32'h0);
    put(KIND_READ, 31, 32'h0);
    // Codes above 32 saturate.
    write_width(6'd63);
    put(KIND_READ, 1023, 32'h0);
    put(KIND_WRITE, 1, 32'h0);
    // Slot straddling a word boundary.
    write_width(6'd5);
    put(KIND_WRITE, 6, 32'hFFFF_FFFF);
    put(KIND_READ, 6, 32'h0);
    put(KIND_READ, 5, 32'h0);
    put(KIND_WRITE, 7, 32'h0000_0015);
    put(KIND_READ, 7, 32'h0);

    foreach (phase_codes[p]) begin
      write_width(phase_codes[p]);
      w = (phase_codes[p] == 0) ? 1 : ((phase_codes[p] > 32) ? 32 : phase_codes[p]);
      nslots = 32768 / w;
      base = $urandom_range(0, nslots - 16);
      repeat (122) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 1);
        if (r < 60) begin
          slot = base + $urandom_range(0, 15);
        end else if (r < 75) begin
          slot = nslots - 1 - $urandom_range(0, 3);
        end else if (r < 85 && nslots < 32768) begin
          slot = $urandom_range(nslots, 32767);
        end else begin
          slot = $urandom_range(0, 32767);
        end
        case ($urandom_range(0, 7))
          0: v = 32'h0;
          1: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        put(k, slot, v);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d reads and %0d writes over %0d width settings", n_reads, n_writes,
             n_widths + 1);
    $display("widths 1 to 32 incl. zero and saturated codes, edge slots and out-of-range");
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
